// ===== design/pli_pkg.sv =====
package pli_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int CMD_W       = 3;
   localparam int VALUE_W     = 31;
   localparam int POS_W       = 7;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_FIELD_W = VALUE_W + COUNT_OUT_W + 2 + STATUS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FIRST = 3'd0,
      CMD_INS_AT    = 3'd1,
      CMD_INS_LAST  = 3'd2,
      CMD_DEL_FIRST = 3'd3,
      CMD_DEL_AT    = 3'd4,
      CMD_DEL_LAST  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic remove;
   } update_type;

endpackage

// ===== design/packed_list_insert_delete_top.sv =====
// channel   direction  tdata (low bit up)                            tuser
// req_      in         value[30:0] position[37:31] zero[39:38]        cmd[2:0]
// rsp_      out        removed_value[30:0] count[37:31] empty_flag[38]
//                      full_flag[39] status[41:40] zero[47:42]        -
//
// one command per cycle while rsp_tready holds; each result passes the command and result registers
// the cell row updates every entry in the same cycle, so the list length sets no limit
// synchronous active-high reset empties the list; entries are not cleared
// a stalled result holds the command register, which then stalls req_tready
module packed_list_insert_delete_top #(
   parameter int DEPTH = pli_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pli_pkg::REQ_TDATA_W-1:0] req_tdata,  // value, position
   input  logic [pli_pkg::CMD_W-1:0]       req_tuser,  // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pli_pkg::RSP_TDATA_W-1:0] rsp_tdata   // removed_value, count, empty_flag,
                                                       // full_flag, status
);

   localparam int IDXW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic                            req_valid_ff;
   pli_pkg::cmd_type                req_cmd_ff;
   logic [pli_pkg::VALUE_W-1:0]     req_value_ff;
   logic [pli_pkg::POS_W-1:0]       req_position_ff;
   logic                            rsp_valid_ff;
   logic [pli_pkg::RSP_FIELD_W-1:0] rsp_data_ff;
   logic [pli_pkg::RSP_FIELD_W-1:0] rsp_data_in;

   logic                            advance;
   pli_pkg::update_type             upd;
   logic [IDXW-1:0]                 at_idx;
   pli_pkg::status_type             status;
   logic [CNTW-1:0]                 count_next;
   logic [CNTW+pli_pkg::COUNT_OUT_W-1:0] count_ext;
   logic [pli_pkg::VALUE_W-1:0]     removed_value;
   logic                            empty_flag;
   logic                            full_flag;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_cmd_ff      <= pli_pkg::cmd_type'(req_tuser);
         req_value_ff    <= req_tdata[pli_pkg::VALUE_W-1:0];
         req_position_ff <= req_tdata[pli_pkg::VALUE_W+pli_pkg::POS_W-1:pli_pkg::VALUE_W];
      end
   end

   pli_ctrl #(
      .DEPTH (DEPTH),
      .IDXW  (IDXW),
      .CNTW  (CNTW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cmd        (req_cmd_ff),
      .position   (req_position_ff),
      .upd        (upd),
      .at_idx     (at_idx),
      .status     (status),
      .count_next (count_next)
   );

   pli_cell_array #(
      .DEPTH (DEPTH),
      .IDXW  (IDXW)
   ) u_cells (
      .clock         (clock),
      .advance       (advance),
      .upd           (upd),
      .at_idx        (at_idx),
      .value         (req_value_ff),
      .removed_value (removed_value)
   );

   assign count_ext   = (CNTW + pli_pkg::COUNT_OUT_W)'(count_next);
   assign empty_flag  = (count_next == '0);
   assign full_flag   = (count_next == CNTW'(DEPTH));
   assign rsp_data_in = {status, full_flag, empty_flag,
                         count_ext[pli_pkg::COUNT_OUT_W-1:0], removed_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pli_pkg::RSP_TDATA_W'(rsp_data_ff);

endmodule

// ===== design/pli_ctrl.sv =====
module pli_ctrl #(
   parameter int DEPTH = pli_pkg::DEPTH_DEFAULT,
   parameter int IDXW  = $clog2(DEPTH),
   parameter int CNTW  = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  pli_pkg::cmd_type          cmd,
   input  logic [pli_pkg::POS_W-1:0] position,
   output pli_pkg::update_type       upd,
   output logic [IDXW-1:0]           at_idx,
   output pli_pkg::status_type       status,
   output logic [CNTW-1:0]           count_next
);

   localparam int CMPW = (CNTW > pli_pkg::POS_W) ? CNTW : pli_pkg::POS_W;

   logic [CNTW-1:0] fill_count_ff;
   logic [CNTW-1:0] fill_count_in;
   logic [CMPW-1:0] cnt_ext;
   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] at_cmp;
   logic            is_full;
   logic            is_empty;

   assign cnt_ext  = CMPW'(fill_count_ff);
   assign pos_ext  = CMPW'(position);
   assign is_full  = (fill_count_ff == CNTW'(DEPTH));
   assign is_empty = (fill_count_ff == '0);

   always_comb begin
      upd    = '0;
      status = pli_pkg::ST_OK;
      at_cmp = '0;
      unique case (cmd) inside
         pli_pkg::CMD_INS_FIRST, pli_pkg::CMD_INS_AT, pli_pkg::CMD_INS_LAST: begin
            if (cmd == pli_pkg::CMD_INS_LAST) begin
               at_cmp = cnt_ext;
            end else if (cmd == pli_pkg::CMD_INS_AT) begin
               at_cmp = pos_ext;
            end
            if (is_full) begin
               status = pli_pkg::ST_FULL;
            end else if (at_cmp > cnt_ext) begin
               status = pli_pkg::ST_BAD_INDEX;
            end else begin
               upd.load = 1'b1;
            end
         end
         pli_pkg::CMD_DEL_FIRST, pli_pkg::CMD_DEL_AT, pli_pkg::CMD_DEL_LAST: begin
            if (cmd == pli_pkg::CMD_DEL_LAST) begin
               at_cmp = cnt_ext - CMPW'(1);
            end else if (cmd == pli_pkg::CMD_DEL_AT) begin
               at_cmp = pos_ext;
            end
            if (is_empty) begin
               status = pli_pkg::ST_EMPTY;
            end else if (at_cmp >= cnt_ext) begin
               status = pli_pkg::ST_BAD_INDEX;
            end else begin
               upd.remove = 1'b1;
            end
         end
         default: begin
            upd = '0;
         end
      endcase
   end

   assign at_idx = at_cmp[IDXW-1:0];

   always_comb begin
      if (upd.load) begin
         fill_count_in = fill_count_ff + CNTW'(1);
      end else if (upd.remove) begin
         fill_count_in = fill_count_ff - CNTW'(1);
      end else begin
         fill_count_in = fill_count_ff;
      end
   end

   assign count_next = fill_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (advance) begin
         fill_count_ff <= fill_count_in;
      end
   end

endmodule

// ===== design/pli_cell_array.sv =====
module pli_cell_array #(
   parameter int DEPTH = pli_pkg::DEPTH_DEFAULT,
   parameter int IDXW  = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        advance,
   input  pli_pkg::update_type         upd,
   input  logic [IDXW-1:0]             at_idx,
   input  logic [pli_pkg::VALUE_W-1:0] value,
   output logic [pli_pkg::VALUE_W-1:0] removed_value
);

   logic [pli_pkg::VALUE_W-1:0] entries_ff [DEPTH];
   logic [pli_pkg::VALUE_W-1:0] entries_in [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [pli_pkg::VALUE_W-1:0] from_below;
      logic [pli_pkg::VALUE_W-1:0] from_above;

      if (i == 0) begin : g_first
         assign from_below = entries_ff[i];
      end else begin : g_inner_lo
         assign from_below = entries_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign from_above = entries_ff[i];
      end else begin : g_inner_hi
         assign from_above = entries_ff[i+1];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (upd.load) begin
            if (at_idx == IDXW'(i)) begin
               entries_in[i] = value;
            end else if (at_idx < IDXW'(i)) begin
               entries_in[i] = from_below;
            end
         end else if (upd.remove) begin
            if (at_idx <= IDXW'(i)) begin
               entries_in[i] = from_above;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   // one-hot select of the entry leaving the list
   always_comb begin
      removed_value = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (upd.remove && at_idx == IDXW'(k)) begin
            removed_value = removed_value | entries_ff[k];
         end
      end
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int LIST_DEPTH    = pli_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 800;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 100;
   localparam int DRAIN_CYCLES  = 20;
   localparam logic [pli_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [pli_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [pli_pkg::VALUE_W-1:0]     removed_value;
      logic [pli_pkg::COUNT_OUT_W-1:0] count;
      logic                            empty_flag;
      logic                            full_flag;
      pli_pkg::status_type             status;
   } outcome_type;

   class list_scoreboard;
      int unsigned                 depth;
      logic [pli_pkg::VALUE_W-1:0] shadow_list[$];
      outcome_type                 outcomes_due[$];
      int unsigned                 mismatches;
      int unsigned                 results_seen;

      function new(int unsigned list_depth);
         depth = list_depth;
      endfunction

      function int unsigned length();
         return shadow_list.size();
      endfunction

      function int unsigned pending();
         return outcomes_due.size();
      endfunction

      function void note_request(logic [pli_pkg::CMD_W-1:0] cmd,
                                 logic [pli_pkg::VALUE_W-1:0] value,
                                 logic [pli_pkg::POS_W-1:0] pos);
         int unsigned fill;
         int unsigned at;
         outcome_type due;
         fill = shadow_list.size();
         due = '0;
         due.status = pli_pkg::ST_OK;
         case (cmd) inside
            pli_pkg::CMD_INS_FIRST, pli_pkg::CMD_INS_AT, pli_pkg::CMD_INS_LAST: begin
               at = (cmd == pli_pkg::CMD_INS_FIRST) ? 0 :
                    (cmd == pli_pkg::CMD_INS_LAST) ? fill : pos;
               if (fill >= depth)
                  due.status = pli_pkg::ST_FULL;
               else if (at > fill)
                  due.status = pli_pkg::ST_BAD_INDEX;
               else
                  shadow_list.insert(at, value);
            end
            pli_pkg::CMD_DEL_FIRST, pli_pkg::CMD_DEL_AT, pli_pkg::CMD_DEL_LAST: begin
               if (fill == 0) begin
                  due.status = pli_pkg::ST_EMPTY;
               end else begin
                  at = (cmd == pli_pkg::CMD_DEL_FIRST) ? 0 :
                       (cmd == pli_pkg::CMD_DEL_LAST) ? fill - 1 : pos;
                  if (at >= fill) begin
                     due.status = pli_pkg::ST_BAD_INDEX;
                  end else begin
                     due.removed_value = shadow_list[at];
                     shadow_list.delete(at);
                  end
               end
            end
            default: ;
         endcase
         due.count      = pli_pkg::COUNT_OUT_W'(shadow_list.size());
         due.empty_flag = (shadow_list.size() == 0);
         due.full_flag  = (shadow_list.size() == depth);
         outcomes_due.push_back(due);
      endfunction

      task report_mismatch(string field, longint unsigned got, longint unsigned want);
         mismatches++;
         if (mismatches <= 50)
            $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
      endtask

      task check_result(logic [pli_pkg::RSP_TDATA_W-1:0] tdata);
         outcome_type got;
         outcome_type want;
         got.removed_value = tdata[30:0];
         got.count         = tdata[37:31];
         got.empty_flag    = tdata[38];
         got.full_flag     = tdata[39];
         got.status        = pli_pkg::status_type'(tdata[41:40]);
         results_seen++;
         if (outcomes_due.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
            return;
         end
         want = outcomes_due.pop_front();
         if (got.removed_value !== want.removed_value)
            report_mismatch("removed_value", got.removed_value, want.removed_value);
         if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
         if (got.empty_flag !== want.empty_flag)
            report_mismatch("empty_flag", got.empty_flag, want.empty_flag);
         if (got.full_flag !== want.full_flag)
            report_mismatch("full_flag", got.full_flag, want.full_flag);
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [pli_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [pli_pkg::CMD_W-1:0]       req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [pli_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   bit             no_gaps;
   int unsigned    cycle_count;
   list_scoreboard sb = new(LIST_DEPTH);

   packed_list_insert_delete_top #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[30:0], req_tdata[37:31]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   // receiver: random stalls, one long hold-off to back the block up
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      hold_left  = 0;
      hold_done  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            hold_done  = 1;
            hold_left  = HOLD_CYCLES - 1;
         end else begin
            rsp_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 31);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("packed_list_insert_delete_top: mismatch");
      $finish;
   end

   task automatic send_cmd(input logic [pli_pkg::CMD_W-1:0] cmd,
                           input logic [pli_pkg::VALUE_W-1:0] value,
                           input logic [pli_pkg::POS_W-1:0] pos);
      while (!no_gaps && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, pos, value};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [pli_pkg::CMD_W-1:0]   cmd;
      logic [pli_pkg::VALUE_W-1:0] value;
      logic [pli_pkg::POS_W-1:0]   pos;
      int unsigned                 len;
      bit                          filling;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      no_gaps    = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // refusals on an empty list, then the edges of value and position
      send_cmd(pli_pkg::CMD_DEL_FIRST, pli_pkg::VALUE_W'($urandom()),
               pli_pkg::POS_W'($urandom()));
      send_cmd(pli_pkg::CMD_DEL_AT,    pli_pkg::VALUE_W'($urandom()), 7'd0);
      send_cmd(pli_pkg::CMD_DEL_LAST,  pli_pkg::VALUE_W'($urandom()),
               pli_pkg::POS_W'($urandom()));
      send_cmd(pli_pkg::CMD_INS_AT,    31'h1234_5678, 7'd1);
      send_cmd(pli_pkg::CMD_INS_FIRST, 31'h7fff_ffff, 7'd127);
      send_cmd(pli_pkg::CMD_INS_LAST,  31'h0, 7'd0);
      send_cmd(pli_pkg::CMD_INS_AT,    31'h5, 7'd2);
      send_cmd(pli_pkg::CMD_INS_AT,    31'h2aaa_aaaa, 7'd1);
      send_cmd(pli_pkg::CMD_INS_AT,    31'h5555_5555, 7'd127);
      send_cmd(pli_pkg::CMD_INS_AT,    31'h1, 7'd5);
      send_cmd(CMD_SPARE_6,            31'h7fff_ffff, 7'd127);
      send_cmd(CMD_SPARE_7,            31'h3, 7'd0);
      send_cmd(pli_pkg::CMD_DEL_AT,    31'h7fff_ffff, 7'd4);
      send_cmd(pli_pkg::CMD_DEL_AT,    31'h0, 7'd127);
      send_cmd(pli_pkg::CMD_DEL_AT,    31'h0, 7'd64);
      send_cmd(pli_pkg::CMD_DEL_AT,    31'h0, 7'd1);
      send_cmd(pli_pkg::CMD_DEL_FIRST, 31'h0, 7'd0);
      send_cmd(pli_pkg::CMD_DEL_LAST,  31'h0, 7'd0);
      send_cmd(pli_pkg::CMD_DEL_LAST,  31'h0, 7'd0);
      send_cmd(pli_pkg::CMD_DEL_AT,    31'h0, 7'd0);
      send_cmd(pli_pkg::CMD_INS_FIRST, 31'h5555_5555, 7'd0);

      // fill and drain sweeps so the list reaches full and empty repeatedly
      filling = 1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_gaps = (i >= 400 && i < 520);
         len = sb.length();
         if (filling && len == LIST_DEPTH && $urandom_range(3) == 0)
            filling = 0;
         else if (!filling && len == 0 && $urandom_range(3) == 0)
            filling = 1;
         case ($urandom_range(9))
            0:       value = 31'h0;
            1:       value = 31'h7fff_ffff;
            default: value = pli_pkg::VALUE_W'($urandom());
         endcase
         if ($urandom_range(99) < 8) begin
            cmd = pli_pkg::CMD_W'($urandom_range(7));
            pos = pli_pkg::POS_W'($urandom());
         end else if ((filling ? 75 : 25) > $urandom_range(99)) begin
            case ($urandom_range(2))
               0:       cmd = pli_pkg::CMD_INS_FIRST;
               1:       cmd = pli_pkg::CMD_INS_AT;
               default: cmd = pli_pkg::CMD_INS_LAST;
            endcase
            pos = ($urandom_range(9) == 0) ? pli_pkg::POS_W'($urandom()) :
                                             pli_pkg::POS_W'($urandom_range(len));
         end else begin
            case ($urandom_range(2))
               0:       cmd = pli_pkg::CMD_DEL_FIRST;
               1:       cmd = pli_pkg::CMD_DEL_AT;
               default: cmd = pli_pkg::CMD_DEL_LAST;
            endcase
            if (len == 0 || $urandom_range(9) == 0)
               pos = pli_pkg::POS_W'($urandom());
            else
               pos = pli_pkg::POS_W'($urandom_range(len - 1));
         end
         send_cmd(cmd, value, pos);
      end
      req_tvalid <= 1'b0;
      no_gaps = 0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("packed_list_insert_delete_top: match");
      else
         $display("packed_list_insert_delete_top: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/pli_pkg.sv
design/pli_ctrl.sv
design/pli_cell_array.sv
design/packed_list_insert_delete_top.sv
dv/tb_top.sv
